// ----- hw/rtl/tlbp_pkg.sv -----
`default_nettype none
package tlbp_pkg;

	// table geometry
	localparam int ENTRIES  = 16;
	localparam int MAX_HIST = 8;
	localparam int IB       = $clog2(ENTRIES + 1) - 1;
	localparam int ROWS     = 1 << IB;
	localparam int LOC_AW   = IB + MAX_HIST;
	localparam int LOC_DEPTH = 1 << LOC_AW;
	localparam int SHR_DEPTH = 1 << MAX_HIST;
	localparam int TAG_W    = 30;
	localparam int TAG_MAX  = 30 - IB;
	localparam int SHARE_HI_LSB = 16;

	// reset values of the registers
	localparam logic [3:0] RST_HISTORY_BITS = 4'd2;
	localparam logic [4:0] RST_TAG_BITS     = 5'd8;
	localparam logic [1:0] RST_INIT_CTR     = 2'd1;

	typedef enum logic [2:0] {
		REG_HISTORY_BITS = 3'd0,
		REG_TAG_BITS     = 3'd1,
		REG_INIT_CTR     = 3'd2,
		REG_GLOBAL_HIST  = 3'd3,
		REG_GLOBAL_TABLE = 3'd4,
		REG_SHARE_MODE   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		SHARE_NONE = 2'd0,
		SHARE_LOW  = 2'd1,
		SHARE_HIGH = 2'd2
	} share_t;

	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_EVAL,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic [3:0] history_bits;
		logic [4:0] tag_bits;
		logic [1:0] initial_counter;
		logic       global_history;
		logic       global_table;
		logic [1:0] share_mode;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic evaluate;
		logic sweep;
		logic clear;
	} ctl_t;

	typedef struct packed {
		logic needs_sweep;
		logic sweep_last;
		logic clear_last;
	} sts_t;

	// 2-bit saturating counter step
	function automatic logic [1:0] train(input logic [1:0] c, input logic t);
		logic [1:0] r;
		if (t) begin
			r = (c == 2'd3) ? 2'd3 : c + 2'd1;
		end else begin
			r = (c == 2'd0) ? 2'd0 : c - 2'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tlbp_regs.sv -----
`default_nettype none
module tlbp_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	output tlbp_pkg::cfg_t           cfg
);
	tlbp_pkg::cfg_t cfg_q;
	tlbp_pkg::reg_idx_t idx;
	logic wr;

	assign idx    = tlbp_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.history_bits    <= tlbp_pkg::RST_HISTORY_BITS;
			cfg_q.tag_bits        <= tlbp_pkg::RST_TAG_BITS;
			cfg_q.initial_counter <= tlbp_pkg::RST_INIT_CTR;
			cfg_q.global_history  <= 1'b0;
			cfg_q.global_table    <= 1'b0;
			cfg_q.share_mode      <= 2'd0;
		end else if (wr) begin
			unique case (idx)
				tlbp_pkg::REG_HISTORY_BITS: cfg_q.history_bits    <= pwdata[3:0];
				tlbp_pkg::REG_TAG_BITS:     cfg_q.tag_bits        <= pwdata[4:0];
				tlbp_pkg::REG_INIT_CTR:     cfg_q.initial_counter <= pwdata[1:0];
				tlbp_pkg::REG_GLOBAL_HIST:  cfg_q.global_history  <= pwdata[0];
				tlbp_pkg::REG_GLOBAL_TABLE: cfg_q.global_table    <= pwdata[0];
				tlbp_pkg::REG_SHARE_MODE:   cfg_q.share_mode      <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = 32'd0;
		unique case (idx)
			tlbp_pkg::REG_HISTORY_BITS: prdata = {28'd0, cfg_q.history_bits};
			tlbp_pkg::REG_TAG_BITS:     prdata = {27'd0, cfg_q.tag_bits};
			tlbp_pkg::REG_INIT_CTR:     prdata = {30'd0, cfg_q.initial_counter};
			tlbp_pkg::REG_GLOBAL_HIST:  prdata = {31'd0, cfg_q.global_history};
			tlbp_pkg::REG_GLOBAL_TABLE: prdata = {31'd0, cfg_q.global_table};
			tlbp_pkg::REG_SHARE_MODE:   prdata = {30'd0, cfg_q.share_mode};
			default:                    prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// ----- hw/rtl/tlbp_ctrl.sv -----
`default_nettype none
module tlbp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  tlbp_pkg::sts_t     sts,
	output tlbp_pkg::ctl_t     ctl,
	output logic               busy
);
	tlbp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlbp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence one request: lookup, evaluate, optional row sweep
	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		busy         = 1'b1;
		unique case (state_q)
			tlbp_pkg::ST_CLEAR: begin
				ctl.clear = 1'b1;
				if (sts.clear_last) state_d = tlbp_pkg::ST_IDLE;
			end
			tlbp_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.capture = 1'b1;
					state_d     = tlbp_pkg::ST_LOOKUP;
				end
			end
			tlbp_pkg::ST_LOOKUP: begin
				state_d = tlbp_pkg::ST_EVAL;
			end
			tlbp_pkg::ST_EVAL: begin
				ctl.evaluate = 1'b1;
				state_d = sts.needs_sweep ? tlbp_pkg::ST_SWEEP : tlbp_pkg::ST_IDLE;
			end
			tlbp_pkg::ST_SWEEP: begin
				ctl.sweep = 1'b1;
				if (sts.sweep_last) state_d = tlbp_pkg::ST_IDLE;
			end
			default: state_d = tlbp_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- hw/rtl/tlbp_dp.sv -----
`default_nettype none
module tlbp_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  tlbp_pkg::cfg_t     cfg,
	input  tlbp_pkg::ctl_t     ctl,
	output tlbp_pkg::sts_t     sts,
	input  wire logic          cmd,
	input  wire logic [31:0]   pc,
	input  wire logic [31:0]   branch_target,
	input  wire logic          taken,
	input  wire logic [31:0]   earlier_prediction,
	output logic               done,
	output logic               predict_taken,
	output logic [31:0]        next_pc,
	output logic               mispredict,
	output logic [31:0]        branches_seen,
	output logic [31:0]        flushes_seen
);
	localparam int IB   = tlbp_pkg::IB;
	localparam int MH   = tlbp_pkg::MAX_HIST;
	localparam int AW   = tlbp_pkg::LOC_AW;

	// request capture
	logic        cmd_q, taken_q;
	logic [31:0] pc_q, tgt_q, pred_q;

	// entry state
	logic                      valid_q [tlbp_pkg::ROWS];
	logic [tlbp_pkg::TAG_W-1:0] tag_q  [tlbp_pkg::ROWS];
	logic [MH-1:0]             ehist_q [tlbp_pkg::ROWS];
	logic [31:0]               target_q[tlbp_pkg::ROWS];
	logic [MH-1:0]             ghist_q;
	logic [31:0]               bcnt_q, fcnt_q;

	// counter memories
	logic [1:0] loc_mem [tlbp_pkg::LOC_DEPTH];
	logic [1:0] shr_mem [tlbp_pkg::SHR_DEPTH];
	logic [1:0] loc_rd_q, shr_rd_q;
	logic [AW-1:0] cnt_q;

	logic [IB-1:0]   idx;
	logic [4:0]      tw;
	logic [29:0]     tag_mask, tag;
	logic            hit;
	logic [3:0]      hl;
	logic [MH-1:0]   m, xr, h, ridx, hnew;
	logic [AW-1:0]   loc_addr;
	logic            commit, mp;
	logic [31:0]     pc4;
	logic [1:0]      ctr;

	// decode the captured PC
	always_comb begin
		idx      = pc_q[2 +: IB];
		tw       = (cfg.tag_bits > 5'(tlbp_pkg::TAG_MAX)) ? 5'(tlbp_pkg::TAG_MAX) : cfg.tag_bits;
		tag_mask = ~({30{1'b1}} << tw);
		tag      = 30'(pc_q >> (2 + IB)) & tag_mask;
		hit      = valid_q[idx] && (tag_q[idx] == tag);
		hl       = (cfg.history_bits > 4'(MH)) ? 4'(MH) : cfg.history_bits;
		m        = ~({MH{1'b1}} << hl);
		unique case (cfg.share_mode)
			tlbp_pkg::SHARE_LOW:  xr = pc_q[2 +: MH] & m;
			tlbp_pkg::SHARE_HIGH: xr = pc_q[tlbp_pkg::SHARE_HI_LSB +: MH] & m;
			default:              xr = '0;
		endcase
		if (cfg.global_history) begin
			h = ghist_q & m;
		end else begin
			h = hit ? (ehist_q[idx] & m) : '0;
		end
		ridx     = (h ^ xr) & m;
		hnew     = ((h << 1) & m) | MH'(taken_q);
		loc_addr = {idx, h};
		pc4      = pc_q + 32'd4;
		mp       = taken_q ? (tgt_q != pred_q) : (pred_q != pc4);
		ctr      = cfg.global_table ? shr_rd_q : loc_rd_q;
	end

	assign sts = '{
		needs_sweep: (cmd_q == tlbp_pkg::CMD_UPDATE) && !cfg.global_table && !hit,
		sweep_last:  (cnt_q[MH-1:0] == {MH{1'b1}}),
		clear_last:  (cnt_q == {AW{1'b1}})
	};
	assign commit = (ctl.evaluate && !sts.needs_sweep) || (ctl.sweep && sts.sweep_last);

	// capture request
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= cmd;
			pc_q    <= pc;
			tgt_q   <= branch_target;
			taken_q <= taken;
			pred_q  <= earlier_prediction;
		end
	end

	// counter memories: one write port, one registered read each
	always_ff @(posedge clk) begin
		loc_rd_q <= loc_mem[loc_addr];
		shr_rd_q <= shr_mem[ridx];
		if (ctl.clear) begin
			loc_mem[cnt_q] <= tlbp_pkg::RST_INIT_CTR;
			if (cnt_q[AW-1:MH] == '0) shr_mem[cnt_q[MH-1:0]] <= tlbp_pkg::RST_INIT_CTR;
		end else if (ctl.sweep) begin
			loc_mem[{idx, cnt_q[MH-1:0]}] <= (cnt_q[MH-1:0] == h)
				? tlbp_pkg::train(cfg.initial_counter, taken_q) : cfg.initial_counter;
		end else if (commit && cmd_q == tlbp_pkg::CMD_UPDATE) begin
			if (cfg.global_table) begin
				shr_mem[ridx] <= tlbp_pkg::train(shr_rd_q, taken_q);
			end else begin
				loc_mem[loc_addr] <= tlbp_pkg::train(loc_rd_q, taken_q);
			end
		end
	end

	// step the clear and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.evaluate) begin
			cnt_q <= '0;
		end else if (ctl.clear || ctl.sweep) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// train history, install entry, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tlbp_pkg::ROWS; i++) begin
				valid_q[i]  <= 1'b0;
				tag_q[i]    <= '0;
				ehist_q[i]  <= '0;
				target_q[i] <= '0;
			end
			ghist_q <= '0;
			bcnt_q  <= '0;
			fcnt_q  <= '0;
		end else if (commit && cmd_q == tlbp_pkg::CMD_UPDATE) begin
			if (cfg.global_history) begin
				ghist_q <= hnew;
			end else begin
				ehist_q[idx] <= hnew;
			end
			valid_q[idx]  <= 1'b1;
			tag_q[idx]    <= tag;
			target_q[idx] <= tgt_q;
			bcnt_q        <= bcnt_q + 32'd1;
			if (mp) fcnt_q <= fcnt_q + 32'd1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= commit;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (commit) begin
			if (cmd_q == tlbp_pkg::CMD_PREDICT) begin
				predict_taken <= hit && ctr[1];
				next_pc       <= (hit && ctr[1]) ? target_q[idx] : pc4;
				mispredict    <= 1'b0;
				branches_seen <= bcnt_q;
				flushes_seen  <= fcnt_q;
			end else begin
				predict_taken <= 1'b0;
				next_pc       <= 32'd0;
				mispredict    <= mp;
				branches_seen <= bcnt_q + 32'd1;
				flushes_seen  <= mp ? fcnt_q + 32'd1 : fcnt_q;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/two_level_branch_predictor.sv -----
`default_nettype none
// Branch target buffer with a two-level direction predictor.
// Requests: raise start with cmd, pc, branch_target, taken and earlier_prediction;
// the request is taken at a clock edge where start is high and busy is low.
// cmd predict returns predict_taken and next_pc; cmd update trains the counters
// and history, installs the entry and returns mispredict with the branch and
// flush counts. Each request gives one result, shown for exactly one cycle
// with done high; the receiver cannot stall and must take it then.
// A predict, an update that hits, or an update with the shared counter table
// finishes after capture, counter memory read and evaluate. An update that misses
// with per-entry counter tables rewrites the entry's 256 local counters one a
// cycle through the single memory write port before it finishes.
// busy drops in the cycle done is high, so the next request can be taken then.
// Reset: after arst_n releases, a clearing pass loads every local counter, one
// per cycle, and the shared counters alongside, with busy high; register writes
// on the APB port are taken throughout.
module two_level_branch_predictor (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	input  wire logic          start,
	output logic               busy,
	input  wire logic          cmd,
	input  wire logic [31:0]   pc,
	input  wire logic [31:0]   branch_target,
	input  wire logic          taken,
	input  wire logic [31:0]   earlier_prediction,
	output logic               done,
	output logic               predict_taken,
	output logic [31:0]        next_pc,
	output logic               mispredict,
	output logic [31:0]        branches_seen,
	output logic [31:0]        flushes_seen
);
	tlbp_pkg::cfg_t cfg;
	tlbp_pkg::ctl_t ctl;
	tlbp_pkg::sts_t sts;

	tlbp_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	tlbp_ctrl u_ctrl (
		.clk, .arst_n, .start, .sts, .ctl, .busy
	);

	tlbp_dp u_dp (
		.clk, .arst_n, .cfg, .ctl, .sts,
		.cmd, .pc, .branch_target, .taken, .earlier_prediction,
		.done, .predict_taken, .next_pc, .mispredict, .branches_seen, .flushes_seen
	);

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while still busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("request not held busy");
`endif
endmodule
`default_nettype wire
